>>> rtl/kts_pkg.sv
`default_nettype none
package kts_pkg;
    localparam int MaxKeysDefault = 64;
    localparam int TimeW = 32;
    localparam int ValW = 32;
    localparam int CountW = 7;
    localparam int IdxW = 6;
    localparam int AddrW = 4;

    localparam logic [1:0] OpWrite = 2'd0;
    localparam logic [1:0] OpRestart = 2'd1;
    localparam logic [1:0] OpAdvance = 2'd2;

    localparam logic [AddrW-1:0] RegKeyCount = 4'h0;
    localparam logic [AddrW-1:0] RegDuration = 4'h4;
    localparam logic [AddrW-1:0] RegLooping = 4'h8;

    localparam logic [31:0] DurationReset = 32'h0001_0000;

    typedef struct packed {
        logic [1:0] op;
        logic [IdxW-1:0] key_index;
        logic [TimeW-1:0] key_time;
        logic signed [ValW-1:0] key_x;
        logic signed [ValW-1:0] key_y;
        logic signed [ValW-1:0] key_z;
        logic [TimeW-1:0] delta;
    } t_in_item;

    typedef struct packed {
        logic signed [ValW-1:0] pos_x;
        logic signed [ValW-1:0] pos_y;
        logic signed [ValW-1:0] pos_z;
    } t_out_item;
endpackage
`default_nettype wire

>>> rtl/kts_in_if.sv
`default_nettype none
interface kts_in_if;
    logic valid;
    logic ready;
    kts_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/kts_out_if.sv
`default_nettype none
interface kts_out_if;
    logic valid;
    logic ready;
    kts_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/keyframe_track_sampler.sv
`default_nettype none
// channel   dir  handshake       payload
// in        in   valid/ready     op, key_index, key_time, key_x/y/z, delta
// out       out  valid/ready     pos_x, pos_y, pos_z
// apb       in   psel/penable    key_count, duration, looping
// a write or restart is done in S_IDLE; an advance runs the modulo, a serial
// key search with a read and a compare per key, the blend factor division and
// 3 multiplies on the shared multiplier.
// key reads go through one registered memory port, which sets the search rate.
// synchronous active-low reset clears control state; key memory is not cleared.
// in.ready is low while an item is in work or a result waits on out.
module keyframe_track_sampler
    import kts_pkg::*;
#(
    parameter int MAX_KEYS = kts_pkg::MaxKeysDefault
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    kts_in_if.sink     in,
    kts_out_if.source  out,
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire [kts_pkg::AddrW-1:0] paddr,
    input  wire [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);
    localparam int KW = $clog2(MAX_KEYS);
    localparam int NW = $clog2(MAX_KEYS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_RD0, S_CHK0, S_RDL, S_CHKL, S_SRCH, S_RDA, S_RDB,
        S_DIV, S_MUL, S_OUT
    } t_state;

    t_state r_state;
    logic [CountW-1:0] r_key_count;
    logic [31:0] r_duration;
    logic r_looping;
    logic [31:0] r_play_time;
    logic r_playing;

    logic [TimeW-1:0] r_mem_t [MAX_KEYS];
    logic [ValW-1:0] r_mem_x [MAX_KEYS];
    logic [ValW-1:0] r_mem_y [MAX_KEYS];
    logic [ValW-1:0] r_mem_z [MAX_KEYS];
    logic [KW-1:0] r_raddr;
    logic [TimeW-1:0] r_rd_t;
    logic [ValW-1:0] r_rd_x, r_rd_y, r_rd_z;

    logic [NW-1:0] r_n;
    logic [KW-1:0] r_idx;
    logic [5:0] r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_t0, r_t1;
    logic [ValW-1:0] r_v0x, r_v0y, r_v0z;
    logic [16:0] r_k;
    logic [1:0] r_lane;
    logic signed [ValW-1:0] r_ox, r_oy, r_oz;
    logic r_out_valid;
    logic [31:0] r_time;

    logic [NW-1:0] n_clip;
    logic [32:0] sum;
    logic [32:0] rem_sh, rem_sub;
    logic [31:0] divisor;
    logic signed [32:0] mdiff;
    logic signed [50:0] mprod;
    logic signed [34:0] mq;
    logic signed [ValW-1:0] mv0, mv1;
    logic wr_cfg, in_fire, out_fire;

    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;
    assign in.ready = (r_state == S_IDLE) && !r_out_valid;
    assign in_fire = in.valid && in.ready;
    assign out_fire = out.valid && out.ready;
    assign out.valid = r_out_valid;
    assign out.data.pos_x = r_ox;
    assign out.data.pos_y = r_oy;
    assign out.data.pos_z = r_oz;

    always_comb begin
        unique case (paddr)
            RegKeyCount: prdata = {25'd0, r_key_count};
            RegDuration: prdata = r_duration;
            RegLooping: prdata = {31'd0, r_looping};
            default: prdata = 32'd0;
        endcase
    end

    always_comb begin
        if ({25'd0, r_key_count} > 32'(MAX_KEYS)) begin
            n_clip = NW'(MAX_KEYS);
        end else begin
            n_clip = NW'(r_key_count);
        end
        sum = {1'b0, r_play_time} + {1'b0, in.data.delta};
        divisor = (r_state == S_MOD) ? r_duration : (r_t1 - r_t0);
        rem_sh = {r_rem[31:0], r_quo[31]};
        rem_sub = rem_sh - {1'b0, divisor};
        unique case (r_lane)
            2'd0: begin mv0 = r_v0x; mv1 = r_rd_x; end
            2'd1: begin mv0 = r_v0y; mv1 = r_rd_y; end
            default: begin mv0 = r_v0z; mv1 = r_rd_z; end
        endcase
        mdiff = 33'(mv1) - 33'(mv0);
        mprod = 51'(mdiff) * $signed({34'd0, r_k});
        mq = 35'(mprod >>> 16);
    end

    always_ff @(posedge i_clk) begin
        r_rd_t <= r_mem_t[r_raddr];
        r_rd_x <= r_mem_x[r_raddr];
        r_rd_y <= r_mem_y[r_raddr];
        r_rd_z <= r_mem_z[r_raddr];
        if (in_fire && in.data.op == OpWrite && {26'd0, in.data.key_index} < 32'(MAX_KEYS)) begin
            r_mem_t[KW'(in.data.key_index)] <= in.data.key_time;
            r_mem_x[KW'(in.data.key_index)] <= in.data.key_x;
            r_mem_y[KW'(in.data.key_index)] <= in.data.key_y;
            r_mem_z[KW'(in.data.key_index)] <= in.data.key_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_key_count <= '0;
            r_duration <= DurationReset;
            r_looping <= 1'b0;
            r_play_time <= '0;
            r_playing <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_cfg) begin
                unique case (paddr)
                    RegKeyCount: r_key_count <= pwdata[CountW-1:0];
                    RegDuration: r_duration <= pwdata;
                    RegLooping: r_looping <= pwdata[0];
                    default: ;
                endcase
            end
            if (out_fire) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_n <= n_clip;
                    if (in_fire) begin
                        if (in.data.op == OpRestart) begin
                            r_play_time <= '0;
                            r_playing <= 1'b1;
                        end else if (in.data.op == OpAdvance && r_playing) begin
                            r_time <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                            r_state <= S_MOD;
                            r_cnt <= '0;
                            r_rem <= '0;
                            r_quo <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        end
                    end
                end
                S_MOD: begin
                    if (r_time <= r_duration) begin
                        r_play_time <= r_time;
                        r_state <= S_RD0;
                    end else if (!r_looping) begin
                        r_play_time <= '0;
                        r_playing <= 1'b0;
                        r_state <= S_IDLE;
                    end else if (r_duration == '0) begin
                        r_time <= '0;
                    end else begin
                        r_quo <= {r_quo[30:0], 1'b0};
                        r_rem <= rem_sub[32] ? rem_sh : rem_sub;
                        r_cnt <= r_cnt + 6'd1;
                        if (r_cnt == 6'd31) begin
                            r_time <= rem_sub[32] ? rem_sh[31:0] : rem_sub[31:0];
                        end
                    end
                    r_raddr <= '0;
                end
                S_RD0: r_state <= S_CHK0;
                S_CHK0: begin
                    r_lane <= 2'd0;
                    if (r_n == '0) begin
                        r_ox <= '0; r_oy <= '0; r_oz <= '0;
                        r_state <= S_OUT;
                    end else if (r_n == NW'(1) || r_time <= r_rd_t) begin
                        r_ox <= r_rd_x; r_oy <= r_rd_y; r_oz <= r_rd_z;
                        r_state <= S_OUT;
                    end else begin
                        r_raddr <= KW'(r_n - NW'(1));
                        r_state <= S_RDL;
                    end
                end
                S_RDL: r_state <= S_CHKL;
                S_CHKL: begin
                    r_ox <= r_rd_x; r_oy <= r_rd_y; r_oz <= r_rd_z;
                    if (r_time >= r_rd_t) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= KW'(1);
                        r_raddr <= KW'(1);
                        r_state <= S_SRCH;
                        r_cnt <= '0;
                    end
                end
                S_SRCH: begin
                    // alternate between reading a key and comparing it
                    r_cnt[0] <= ~r_cnt[0];
                    if (r_cnt[0]) begin
                        if (r_time <= r_rd_t) begin
                            r_t1 <= r_rd_t;
                            r_raddr <= r_idx - KW'(1);
                            r_state <= S_RDA;
                        end else if (NW'(r_idx) == r_n - NW'(1)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_idx <= r_idx + KW'(1);
                            r_raddr <= r_idx + KW'(1);
                        end
                    end
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: begin
                    r_t0 <= r_rd_t;
                    r_v0x <= r_rd_x; r_v0y <= r_rd_y; r_v0z <= r_rd_z;
                    r_raddr <= r_idx;
                    if (!(r_time >= r_rd_t) || r_t1 == r_rd_t) begin
                        r_state <= S_OUT;
                    end else begin
                        r_quo <= {r_time - r_rd_t};
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // (t - t0) << 16 over t1 - t0, only 17 quotient bits are nonzero
                    r_quo <= {r_quo[30:0], ~rem_sub[32]};
                    r_rem <= rem_sub[32] ? rem_sh : rem_sub;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd47) begin
                        r_k <= {r_quo[15:0], ~rem_sub[32]};
                        r_lane <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_lane <= r_lane + 2'd1;
                    unique case (r_lane)
                        2'd0: r_ox <= mv0 + 32'(mq);
                        2'd1: r_oy <= mv0 + 32'(mq);
                        default: begin
                            r_oz <= mv0 + 32'(mq);
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !in.ready)
        else $error("input taken while result waits");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> r_out_valid)
        else $error("result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !out.ready) |=> r_out_valid && $stable(r_ox))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import kts_pkg::*;

    localparam int NKeys = 64;
    localparam int IdleLimit = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    kts_in_if in_ch ();
    kts_out_if out_ch ();

    keyframe_track_sampler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in(in_ch.sink), .out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] mdl_t [NKeys];
    logic [31:0] mdl_x [NKeys];
    logic [31:0] mdl_y [NKeys];
    logic [31:0] mdl_z [NKeys];
    logic [31:0] mdl_play;
    logic mdl_playing;
    logic [6:0] cfg_count;
    logic [31:0] cfg_dur;
    logic cfg_loop;
    bit written [NKeys];

    t_in_item pending_items[$];
    t_out_item expected_pos[$];
    int errors = 0;
    int n_items = 0;
    int n_sent = 0;
    int n_pos = 0;
    int idle_cycles = 0;
    int in_gap = 0;
    int out_gap = 0;

    function automatic logic [31:0] lerp(logic [31:0] a, logic [31:0] b, longint k);
        longint v0, p, q;
        v0 = longint'($signed(a));
        p = (longint'($signed(b)) - v0) * k;
        if (p >= 0) q = p / 65536;
        else q = -((-p + 65535) / 65536);
        return 32'(v0 + q);
    endfunction

    function automatic t_out_item sample_at(logic [31:0] t);
        t_out_item r;
        int n, hi, lo;
        longint k;
        n = cfg_count > NKeys ? NKeys : int'(cfg_count);
        hi = 0;
        lo = 0;
        r = '0;
        if (n == 0) return r;
        if (n == 1 || t <= mdl_t[0]) begin
            r.pos_x = mdl_x[0]; r.pos_y = mdl_y[0]; r.pos_z = mdl_z[0];
            return r;
        end
        lo = n - 1;
        r.pos_x = mdl_x[lo]; r.pos_y = mdl_y[lo]; r.pos_z = mdl_z[lo];
        if (t >= mdl_t[n-1]) return r;
        for (int i = 1; i < n; i++) begin
            if (t <= mdl_t[i]) begin
                hi = i;
                break;
            end
        end
        if (hi == 0) return r;
        if (!(t >= mdl_t[hi-1] && t <= mdl_t[hi]) || mdl_t[hi] == mdl_t[hi-1]) return r;
        k = longint'({t - mdl_t[hi-1], 16'h0}) / longint'(mdl_t[hi] - mdl_t[hi-1]);
        r.pos_x = lerp(mdl_x[hi-1], mdl_x[hi], k);
        r.pos_y = lerp(mdl_y[hi-1], mdl_y[hi], k);
        r.pos_z = lerp(mdl_z[hi-1], mdl_z[hi], k);
        return r;
    endfunction

    function automatic void predict_item(t_in_item it);
        logic [32:0] sum;
        case (it.op)
            OpWrite: begin
                mdl_t[it.key_index] = it.key_time;
                mdl_x[it.key_index] = it.key_x;
                mdl_y[it.key_index] = it.key_y;
                mdl_z[it.key_index] = it.key_z;
            end
            OpRestart: begin
                mdl_play = '0;
                mdl_playing = 1'b1;
            end
            OpAdvance: begin
                if (mdl_playing) begin
                    sum = {1'b0, mdl_play} + {1'b0, it.delta};
                    mdl_play = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (mdl_play > cfg_dur) begin
                        if (cfg_loop) begin
                            mdl_play = cfg_dur == 0 ? 32'h0 : mdl_play % cfg_dur;
                        end else begin
                            mdl_play = '0;
                            mdl_playing = 1'b0;
                            return;
                        end
                    end
                    expected_pos = {expected_pos, sample_at(mdl_play)};
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_item(in_ch.data);
                n_items++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_ch.data <= pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                    n_sent++;
                    in_gap = pick_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                n_pos++;
                if (expected_pos.size() == 0) begin
                    $error("unexpected item x=%h y=%h z=%h", out_ch.data.pos_x,
                           out_ch.data.pos_y, out_ch.data.pos_z);
                    errors++;
                end else begin
                    want = expected_pos.pop_front();
                    if (out_ch.data.pos_x !== want.pos_x) begin
                        $error("pos_x expected %h actual %h", want.pos_x, out_ch.data.pos_x);
                        errors++;
                    end
                    if (out_ch.data.pos_y !== want.pos_y) begin
                        $error("pos_y expected %h actual %h", want.pos_y, out_ch.data.pos_y);
                        errors++;
                    end
                    if (out_ch.data.pos_z !== want.pos_z) begin
                        $error("pos_z expected %h actual %h", want.pos_z, out_ch.data.pos_z);
                        errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
            $display("[keyframe_track_sampler] ERROR");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    task automatic apb_write(logic [AddrW-1:0] addr, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (addr)
            RegKeyCount: cfg_count = val[6:0];
            RegDuration: cfg_dur = val;
            RegLooping: cfg_loop = val[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || n_items != n_sent || expected_pos.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic void push_op(logic [1:0] op, logic [5:0] idx, logic [31:0] kt,
                                    logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                    logic [31:0] d);
        t_in_item it;
        it.op = op; it.key_index = idx; it.key_time = kt;
        it.key_x = x; it.key_y = y; it.key_z = z; it.delta = d;
        pending_items = {pending_items, it};
        if (op == OpWrite) written[idx] = 1'b1;
    endfunction

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // keys 0..n-1 with non-decreasing times and random spacing
    function automatic void load_track(int n, int step_max);
        logic [31:0] t;
        t = $urandom_range(0, step_max);
        for (int i = 0; i < n; i++) begin
            push_op(OpWrite, 6'(i), t, rnd_val(), rnd_val(), rnd_val(), $urandom());
            t = t + $urandom_range(0, step_max);
        end
    endfunction

    function automatic int written_prefix();
        int n;
        n = 0;
        while (n < NKeys && written[n]) n++;
        return n;
    endfunction

    initial begin
        int nk, r, span;
        for (int i = 0; i < NKeys; i++) begin
            mdl_t[i] = '0; mdl_x[i] = '0; mdl_y[i] = '0; mdl_z[i] = '0;
            written[i] = 1'b0;
        end
        mdl_play = '0;
        mdl_playing = 1'b0;
        cfg_count = '0;
        cfg_dur = DurationReset;
        cfg_loop = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: no keys, stopped advance, unknown op, restart
        push_op(OpAdvance, 0, 0, 0, 0, 0, 32'h100);
        push_op(2'd3, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
        push_op(OpRestart, 0, 0, 0, 0, 0, 0);
        push_op(OpAdvance, 0, 0, 0, 0, 0, 32'h4000);
        push_op(OpWrite, 0, 32'h0000_8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 0);
        push_op(OpWrite, 1, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        push_op(OpWrite, 2, 32'h0000_8000, 32'h1234_5678, 32'hFFFF_0000, 32'h1, 0);
        push_op(OpWrite, 63, 32'hFFFF_FFFF, 32'h1, 32'h2, 32'h3, 0);
        drain();
        apb_write(RegKeyCount, 32'd1);
        push_op(OpRestart, 0, 0, 0, 0, 0, 0);
        push_op(OpAdvance, 0, 0, 0, 0, 0, 32'h100);
        drain();
        apb_write(RegKeyCount, 32'd3);
        apb_write(RegLooping, 32'd1);
        push_op(OpRestart, 0, 0, 0, 0, 0, 0);
        push_op(OpAdvance, 0, 0, 0, 0, 0, 32'h0);
        push_op(OpAdvance, 0, 0, 0, 0, 0, 32'h4000);
        push_op(OpAdvance, 0, 0, 0, 0, 0, 32'h3FFF);
        push_op(OpAdvance, 0, 0, 0, 0, 0, 32'h0001);
        push_op(OpAdvance, 0, 0, 0, 0, 0, 32'h4000);
        push_op(OpAdvance, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        drain();
        apb_write(RegDuration, 32'd0);
        push_op(OpAdvance, 0, 0, 0, 0, 0, 32'h5);
        drain();
        apb_write(RegLooping, 32'd0);
        apb_write(RegDuration, 32'hFFFF_FFFF);
        push_op(OpRestart, 0, 0, 0, 0, 0, 0);
        push_op(OpAdvance, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        push_op(OpAdvance, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        drain();

        // random phases
        for (int ph = 0; ph < 28; ph++) begin
            nk = (ph % 7 == 3) ? 64 : $urandom_range(0, 8);
            span = $urandom_range(0, 3) == 0 ? 32'h0010_0000 : 32'h0000_4000;
            load_track(nk, span);
            drain();
            r = written_prefix();
            if (nk > 0 && $urandom_range(0, 4) == 0) nk = nk - 1;
            if (ph == 5) apb_write(RegKeyCount, 32'h7F & 32'(r < 64 ? r : 127));
            else apb_write(RegKeyCount, 32'(nk <= r ? nk : r));
            case ($urandom_range(0, 4))
                0: apb_write(RegDuration, 32'd1);
                1: apb_write(RegDuration, 32'hFFFF_FFFF);
                default: apb_write(RegDuration, $urandom_range(1, nk * span + 2));
            endcase
            apb_write(RegLooping, 32'($urandom_range(0, 1)));
            push_op(OpRestart, 0, 0, 0, 0, 0, 0);
            for (int j = 0; j < 16; j++) begin
                r = $urandom_range(0, 19);
                if (r == 0) push_op(OpRestart, 0, 0, 0, 0, 0, 0);
                else if (r == 1) push_op(2'd3, 6'($urandom()), $urandom(), $urandom(),
                                         $urandom(), $urandom(), $urandom());
                else if (r == 2) push_op(OpAdvance, 0, 0, 0, 0, 0, $urandom());
                else push_op(OpAdvance, 6'($urandom()), $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom_range(0, span));
            end
            drain();
        end

        $display("items accepted: %0d, samples checked: %0d", n_items, n_pos);
        $display("covered empty, single and full tracks, looping, stop and saturation");
        if (errors == 0 && expected_pos.size() == 0) begin
            $display("[keyframe_track_sampler] OK");
        end else begin
            $display("[keyframe_track_sampler] ERROR");
        end
        $finish;
    end
endmodule
